// File: rtl/core/tlsiw_pkg.sv
package tlsiw_pkg;

    localparam int BLOCK_SHIFT       = 3;
    localparam int BLOCK_TABLE_DEPTH = 65536;
    localparam int DESCRIPTOR_DEPTH  = 16384;
    localparam int SHAPE_DEPTH       = 65536;
    localparam int MAX_CHAIN         = 63;

    localparam int OFFSET_DEPTH = DESCRIPTOR_DEPTH << (2 * BLOCK_SHIFT);

    localparam int BPT_AW   = $clog2(BLOCK_TABLE_DEPTH);
    localparam int DESC_AW  = $clog2(DESCRIPTOR_DEPTH);
    localparam int OFS_AW   = $clog2(OFFSET_DEPTH);
    localparam int SHAPE_AW = $clog2(SHAPE_DEPTH);

    // pointer entry: valid bit (present and descriptor in range) + descriptor index
    localparam int BPT_W   = 1 + DESC_AW;
    localparam int SHAPE_W = 48;

    // base (16) + offset (8) + at most MAX_CHAIN increments stays below 2^17
    localparam int IDX_W  = 17;
    localparam int CNT_W  = $clog2(MAX_CHAIN + 1);
    localparam int CELL_W = 16 - BLOCK_SHIFT;
    localparam int PROD_W = 2 * CELL_W;
    localparam int BLK_W  = PROD_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT_MASK  = 2'd2;

    localparam logic [15:0] MAP_WIDTH_RST  = 16'd6144;
    localparam logic [15:0] MAP_HEIGHT_RST = 16'd4096;
    localparam logic [31:0] CONT_MASK_RST  = 32'h8000_0000;

    localparam logic [2:0] KIND_QUERY  = 3'd0;
    localparam logic [2:0] KIND_PTR    = 3'd1;
    localparam logic [2:0] KIND_BASE   = 3'd2;
    localparam logic [2:0] KIND_OFFSET = 3'd3;
    localparam logic [2:0] KIND_SHAPE  = 3'd4;

    typedef enum logic [2:0] {
        STAT_SHAPE    = 3'd0,
        STAT_DONE     = 3'd1,
        STAT_LOAD     = 3'd2,
        STAT_RANGE    = 3'd3,
        STAT_MISSING  = 3'd4,
        STAT_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_PTR,
        S_DESC,
        S_IDX,
        S_WALK,
        S_SHAPE,
        S_FIN
    } t_state;

endpackage

// File: rtl/core/tlsiw_ram.sv
module tlsiw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/two_level_solid_index_walk_top.sv
// Load: its result strobes on the next cycle; loads run back to back.
// Query: one at a time; it ends early when out of range, with no continuation or for a
// missing block, else it walks the shape entries until the chain ends or the result cap,
// step limit or shape table bound ends the walk; each store read is registered.
// Results strobe for one cycle and cannot be stalled. Reset (i_rst_n, synchronous, low) clears
// control and config registers; the stores are undefined until loaded, with no clearing pass.
module two_level_solid_index_walk_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [15:0] i_x_coord,
    input  logic [15:0] i_y_coord,
    input  logic [31:0] i_match_flags,
    input  logic [31:0] i_flags_value,
    input  logic signed [7:0] i_z_value,
    input  logic [7:0]  i_height_value,
    input  logic [15:0] i_table_address,
    input  logic [15:0] i_link_value,
    input  logic        i_link_present,
    input  logic        i_cfg_we,
    input  logic [tlsiw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic signed [8:0] o_shape_z,
    output logic [7:0]  o_shape_height,
    output logic [31:0] o_shape_flags,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import tlsiw_pkg::*;

    t_state r_state, n_state;

    logic [15:0] r_map_width;
    logic [15:0] r_map_height;
    logic [31:0] r_cont_mask;

    logic [15:0]      r_x, r_y;
    logic [31:0]      r_match, r_gflags;
    logic [7:0]       r_gz;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [BLK_W-1:0] r_block, n_block;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_steps, n_steps;
    logic [CNT_W-1:0] r_n, n_n;

    logic        r_out_valid, n_out_valid;
    logic [8:0]  r_out_z, n_out_z;
    logic [7:0]  r_out_h, n_out_h;
    logic [31:0] r_out_f, n_out_f;
    t_status     r_out_status, n_out_status;
    logic        r_out_last, n_out_last;

    logic accept;
    logic [31:0] addr32;
    logic        we_bpt, we_base, we_ofs, we_shape;
    logic        load_range;

    logic [BPT_W-1:0]   bpt_rdata;
    logic [15:0]        base_rdata;
    logic [7:0]         ofs_rdata;
    logic [SHAPE_W-1:0] shape_rdata;
    logic [31:0]        block32, idx32;
    logic [BLK_W-1:0]   block_sum;
    logic [DESC_AW-1:0] desc;
    logic [31:0]        sh_flags;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign addr32 = 32'(i_table_address);

    assign we_bpt   = accept && (i_kind == KIND_PTR)    && (addr32 < 32'(BLOCK_TABLE_DEPTH));
    assign we_base  = accept && (i_kind == KIND_BASE)   && (addr32 < 32'(DESCRIPTOR_DEPTH));
    assign we_ofs   = accept && (i_kind == KIND_OFFSET) && (addr32 < 32'(DESCRIPTOR_DEPTH));
    assign we_shape = accept && (i_kind == KIND_SHAPE)  && (addr32 < 32'(SHAPE_DEPTH));

    always_comb begin
        unique case (i_kind)
            KIND_PTR:    load_range = (addr32 >= 32'(BLOCK_TABLE_DEPTH));
            KIND_BASE,
            KIND_OFFSET: load_range = (addr32 >= 32'(DESCRIPTOR_DEPTH));
            KIND_SHAPE:  load_range = (addr32 >= 32'(SHAPE_DEPTH));
            default:     load_range = 1'b0;
        endcase
    end

    // descriptor index that fails the depth check is stored as not present
    tlsiw_ram #(.WIDTH(BPT_W), .DEPTH(BLOCK_TABLE_DEPTH)) u_bpt (
        .i_clk   (i_clk),
        .i_we    (we_bpt),
        .i_waddr (addr32[BPT_AW-1:0]),
        .i_wdata ({i_link_present && (32'(i_link_value) < 32'(DESCRIPTOR_DEPTH)),
                   i_link_value[DESC_AW-1:0]}),
        .i_raddr (block32[BPT_AW-1:0]),
        .o_rdata (bpt_rdata)
    );

    assign desc = bpt_rdata[DESC_AW-1:0];

    tlsiw_ram #(.WIDTH(16), .DEPTH(DESCRIPTOR_DEPTH)) u_base (
        .i_clk   (i_clk),
        .i_we    (we_base),
        .i_waddr (addr32[DESC_AW-1:0]),
        .i_wdata (i_link_value),
        .i_raddr (desc),
        .o_rdata (base_rdata)
    );

    tlsiw_ram #(.WIDTH(8), .DEPTH(OFFSET_DEPTH)) u_ofs (
        .i_clk   (i_clk),
        .i_we    (we_ofs),
        .i_waddr ({addr32[DESC_AW-1:0], i_x_coord[BLOCK_SHIFT-1:0],
                   i_y_coord[BLOCK_SHIFT-1:0]}),
        .i_wdata (i_link_value[7:0]),
        .i_raddr ({desc, r_x[BLOCK_SHIFT-1:0], r_y[BLOCK_SHIFT-1:0]}),
        .o_rdata (ofs_rdata)
    );

    tlsiw_ram #(.WIDTH(SHAPE_W), .DEPTH(SHAPE_DEPTH)) u_shape (
        .i_clk   (i_clk),
        .i_we    (we_shape),
        .i_waddr (addr32[SHAPE_AW-1:0]),
        .i_wdata ({i_flags_value, i_z_value, i_height_value}),
        .i_raddr (idx32[SHAPE_AW-1:0]),
        .o_rdata (shape_rdata)
    );

    assign block_sum = {1'b0, r_prod} + BLK_W'(r_x[15:BLOCK_SHIFT]);
    assign block32   = 32'(r_block);
    assign idx32     = 32'(r_idx);
    assign sh_flags  = shape_rdata[47:16];

    always_comb begin
        n_state      = r_state;
        n_prod       = r_prod;
        n_block      = r_block;
        n_idx        = r_idx;
        n_steps      = r_steps;
        n_n          = r_n;
        n_out_valid  = 1'b0;
        n_out_z      = 9'd0;
        n_out_h      = 8'd0;
        n_out_f      = 32'd0;
        n_out_status = STAT_DONE;
        n_out_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_QUERY) begin
                        n_state = S_MUL;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = load_range ? STAT_RANGE : STAT_LOAD;
                        n_out_last   = 1'b1;
                    end
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_y[15:BLOCK_SHIFT]) * PROD_W'(r_map_width[15:BLOCK_SHIFT]);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_block = block_sum;
                n_n     = '0;
                if (r_x >= r_map_width || r_y >= r_map_height ||
                    32'(block_sum) >= 32'(BLOCK_TABLE_DEPTH)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_RANGE;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    if ((r_gflags & r_match) != 32'd0) begin
                        n_out_valid  = 1'b1;
                        n_out_z      = {r_gz[7], r_gz} - 9'd1;
                        n_out_h      = 8'd1;
                        n_out_f      = r_gflags;
                        n_out_status = STAT_SHAPE;
                        n_n          = CNT_W'(1);
                    end
                    n_state = S_PTR;
                end
            end
            S_PTR: begin
                // pointer read address is r_block, data arrives in S_DESC
                if ((r_gflags & r_cont_mask) == 32'd0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_DONE;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_DESC;
                end
            end
            S_DESC: begin
                if (!bpt_rdata[BPT_W-1]) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_MISSING;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_idx   = IDX_W'(base_rdata) + IDX_W'(ofs_rdata);
                n_steps = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_steps >= CNT_W'(MAX_CHAIN)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OVERFLOW;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else if (idx32 >= 32'(SHAPE_DEPTH)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_RANGE;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE: begin
                if ((sh_flags & r_match) != 32'd0 && r_n >= CNT_W'(MAX_CHAIN)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OVERFLOW;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    if ((sh_flags & r_match) != 32'd0) begin
                        n_out_valid  = 1'b1;
                        n_out_z      = {shape_rdata[15], shape_rdata[15:8]};
                        n_out_h      = shape_rdata[7:0];
                        n_out_f      = sh_flags;
                        n_out_status = STAT_SHAPE;
                        n_n          = r_n + CNT_W'(1);
                    end
                    if ((sh_flags & r_cont_mask) == 32'd0) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_steps = r_steps + CNT_W'(1);
                        n_state = S_WALK;
                    end
                end
            end
            S_FIN: begin
                n_out_valid  = 1'b1;
                n_out_status = STAT_DONE;
                n_out_last   = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_map_width  <= MAP_WIDTH_RST;
            r_map_height <= MAP_HEIGHT_RST;
            r_cont_mask  <= CONT_MASK_RST;
            r_n          <= '0;
            r_steps      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_n         <= n_n;
            r_steps     <= n_steps;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAP_WIDTH) begin
                    r_map_width <= i_cfg_data[15:0];
                end
                if (i_cfg_index == CFG_MAP_HEIGHT) begin
                    r_map_height <= i_cfg_data[15:0];
                end
                if (i_cfg_index == CFG_CONT_MASK) begin
                    r_cont_mask <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x      <= i_x_coord;
            r_y      <= i_y_coord;
            r_match  <= i_match_flags;
            r_gflags <= i_flags_value;
            r_gz     <= i_z_value;
        end
        r_prod       <= n_prod;
        r_block      <= n_block;
        r_idx        <= n_idx;
        r_out_z      <= n_out_z;
        r_out_h      <= n_out_h;
        r_out_f      <= n_out_f;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_shape_z      = r_out_z;
    assign o_shape_height = r_out_h;
    assign o_shape_flags  = r_out_f;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    // a query only ends with its final result
    a_end_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_last))
        else $error("busy dropped without a final result");

    a_shape_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_SHAPE) |-> !o_last)
        else $error("shape result marked last");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind != KIND_QUERY) |=> (o_valid && o_last && !busy))
        else $error("load transaction without a result on the next cycle");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n <= CNT_W'(MAX_CHAIN)) && (r_steps <= CNT_W'(MAX_CHAIN)))
        else $error("result or step count beyond chain limit");
`endif

endmodule
